// ===== hw/rtl/path_vertex_edge_conflict_check_assert.svh =====
// Assertion macros for the path conflict checker
`ifndef PATH_VERTEX_EDGE_CONFLICT_CHECK_ASSERT_SVH
`define PATH_VERTEX_EDGE_CONFLICT_CHECK_ASSERT_SVH
`ifndef SYNTHESIS
`define PVEC_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define PVEC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define PVEC_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)
`define PVEC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/pvec_pkg.sv =====
// Shared constants and types for the path conflict checker
package pvec_pkg;

   localparam int PVEC_MAX_AGENTS  = 64;
   localparam int PVEC_VERTEX_BITS = 16;

   localparam int CFG_W     = 7;
   localparam int VERTEX_W  = 16;
   localparam int STEP_W    = 16;
   localparam int AGENT_W   = 6;
   localparam int STATUS_W  = 2;

   localparam logic [STEP_W-1:0] STEP_MAX = {STEP_W{1'b1}};

   localparam logic [STATUS_W-1:0] ST_NONE   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_VERTEX = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EDGE   = 2'd2;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [AGENT_W-1:0]  agent;
      logic [AGENT_W-1:0]  other_agent;
      logic [STEP_W-1:0]   time_step;
   } result_type;

endpackage

// ===== hw/rtl/pvec_ram.sv =====
// Generic single-write, single-read RAM with registered read data
module pvec_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/pvec_scan.sv =====
// Per-beat sequencer: reads the agent's own row entry, scans earlier agents, writes back
module pvec_scan import pvec_pkg::*; #(
   parameter int MAX_AGENTS  = PVEC_MAX_AGENTS,
   parameter int VERTEX_BITS = PVEC_VERTEX_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [VERTEX_W-1:0]                req_vertex,
   input  logic                               req_restart,
   input  logic [$clog2(MAX_AGENTS+1)-1:0]    agent_count,
   output logic                               ram_wr_en,
   output logic [$clog2(MAX_AGENTS)-1:0]      ram_wr_addr,
   output logic [2*VERTEX_BITS-1:0]           ram_wr_data,
   output logic                               ram_rd_en,
   output logic [$clog2(MAX_AGENTS)-1:0]      ram_rd_addr,
   input  logic [2*VERTEX_BITS-1:0]           ram_rd_data,
   input  logic                               out_free,
   output logic                               out_load,
   output result_type                         out_data
);

   localparam int AW = $clog2(MAX_AGENTS);
   localparam int CW = $clog2(MAX_AGENTS+1);
   localparam int VB = VERTEX_BITS;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SELF = 2'd1;
   localparam logic [1:0] S_SCAN = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   logic [1:0]          state_ff,  state_in;
   logic [AW-1:0]       agent_ff,  agent_in;
   logic [STEP_W-1:0]   step_ff,   step_in;
   logic [VB-1:0]       v_ff,      v_in;
   logic [AW-1:0]       a_ff,      a_in;
   logic [STEP_W-1:0]   t_ff,      t_in;
   logic [VB-1:0]       self_ff,   self_in;
   logic [AW-1:0]       j_ff,      j_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [AW-1:0]       other_ff,  other_in;

   // each row entry holds {vertex before this step, latest vertex}
   logic [VB-1:0] rd_cur;
   logic [VB-1:0] rd_prev;
   logic [AW-1:0] j_next;
   logic [CW-1:0] a_next;

   assign rd_cur  = ram_rd_data[VB-1:0];
   assign rd_prev = ram_rd_data[2*VB-1:VB];
   assign j_next  = j_ff + AW'(1);
   assign a_next  = CW'(a_ff) + CW'(1);

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in    = state_ff;
      agent_in    = agent_ff;
      step_in     = step_ff;
      v_in        = v_ff;
      a_in        = a_ff;
      t_in        = t_ff;
      self_in     = self_ff;
      j_in        = j_ff;
      status_in   = status_ff;
      other_in    = other_ff;
      ram_rd_en   = 1'b0;
      ram_rd_addr = a_ff;
      ram_wr_en   = 1'b0;
      out_load    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               a_in        = req_restart ? '0 : agent_ff;
               t_in        = req_restart ? '0 : step_ff;
               v_in        = VB'(req_vertex);
               ram_rd_en   = 1'b1;
               ram_rd_addr = a_in;
               state_in    = S_SELF;
            end
         end
         S_SELF: begin
            self_in   = rd_cur;
            status_in = ST_NONE;
            other_in  = '0;
            if (t_ff == '0 || a_ff == '0) begin
               state_in = S_DONE;
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = '0;
               j_in        = '0;
               state_in    = S_SCAN;
            end
         end
         S_SCAN: begin
            if (rd_cur == v_ff) begin
               status_in = ST_VERTEX;
               other_in  = j_ff;
               state_in  = S_DONE;
            end else if (rd_prev == v_ff && rd_cur == self_ff) begin
               status_in = ST_EDGE;
               other_in  = j_ff;
               state_in  = S_DONE;
            end else if (j_next == a_ff) begin
               state_in = S_DONE;
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = j_next;
               j_in        = j_next;
            end
         end
         S_DONE: begin
            if (out_free) begin
               out_load  = 1'b1;
               ram_wr_en = 1'b1;
               if (a_next >= agent_count) begin
                  agent_in = '0;
                  step_in  = (t_ff != STEP_MAX) ? t_ff + STEP_W'(1) : t_ff;
               end else begin
                  agent_in = a_ff + AW'(1);
                  step_in  = t_ff;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign ram_wr_addr = a_ff;
   assign ram_wr_data = {self_ff, v_ff};

   assign out_data.status      = status_ff;
   assign out_data.agent       = AGENT_W'(a_ff);
   assign out_data.other_agent = AGENT_W'(other_ff);
   assign out_data.time_step   = t_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         agent_ff <= '0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         agent_ff <= agent_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff      <= v_in;
      a_ff      <= a_in;
      t_ff      <= t_in;
      self_ff   <= self_in;
      j_ff      <= j_in;
      status_ff <= status_in;
      other_ff  <= other_in;
   end

endmodule

// ===== hw/rtl/pvec_outreg.sv =====
// Result register between the sequencer and the response channel
module pvec_outreg import pvec_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  result_type load_data,
   output logic       free,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output result_type rsp_data
);

   logic       valid_ff, valid_in;
   result_type data_ff;

   assign free     = !valid_ff || !rsp_stall;
   assign valid_in = load || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

// ===== hw/rtl/path_vertex_edge_conflict_check.sv =====
// Path conflict checker: top level
// Takes one vertex beat per agent per time step and returns one result beat each, naming the
// lowest earlier agent that shares the vertex or swapped places with it since the last step.
// Both rows live in one RAM whose entries hold an agent's latest and previous vertex, so the
// end of a step needs no copy. For a beat of agent a, the RAM read port scans the earlier agents
// one per cycle and stops at the first hit; at time step 0 or for agent 0 there is no scan, and
// the result may then wait on rsp_stall before the next beat is taken. The agent count
// register resets to 1; 0 acts as 1 and values above MAX_AGENTS act as MAX_AGENTS.
`include "path_vertex_edge_conflict_check_assert.svh"
module path_vertex_edge_conflict_check import pvec_pkg::*; #(
   parameter int MAX_AGENTS  = PVEC_MAX_AGENTS,
   parameter int VERTEX_BITS = PVEC_VERTEX_BITS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [CFG_W-1:0]    csr_wr_data,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [VERTEX_W-1:0] req_vertex,
   input  logic                req_restart,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [AGENT_W-1:0]  rsp_agent,
   output logic [AGENT_W-1:0]  rsp_other_agent,
   output logic [STEP_W-1:0]   rsp_time_step
);

   localparam int AW = $clog2(MAX_AGENTS);
   localparam int CW = $clog2(MAX_AGENTS+1);
   localparam int EW = 2*VERTEX_BITS;

   logic [CFG_W-1:0] num_agents_ff, num_agents_in;
   logic [CW-1:0]    agent_count;

   logic          ram_wr_en;
   logic [AW-1:0] ram_wr_addr;
   logic [EW-1:0] ram_wr_data;
   logic          ram_rd_en;
   logic [AW-1:0] ram_rd_addr;
   logic [EW-1:0] ram_rd_data;

   logic       out_free;
   logic       out_load;
   result_type out_data;
   result_type rsp_data;

   assign num_agents_in = csr_wr_en ? csr_wr_data : num_agents_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_agents_ff <= CFG_W'(1);
      end else begin
         num_agents_ff <= num_agents_in;
      end
   end

   always_comb begin
      if (num_agents_ff == '0) begin
         agent_count = CW'(1);
      end else if (32'(num_agents_ff) > MAX_AGENTS) begin
         agent_count = CW'(MAX_AGENTS);
      end else begin
         agent_count = CW'(num_agents_ff);
      end
   end

   pvec_ram #(
      .WIDTH (EW),
      .DEPTH (MAX_AGENTS)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   pvec_scan #(
      .MAX_AGENTS  (MAX_AGENTS),
      .VERTEX_BITS (VERTEX_BITS)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_vertex  (req_vertex),
      .req_restart (req_restart),
      .agent_count (agent_count),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data),
      .out_free    (out_free),
      .out_load    (out_load),
      .out_data    (out_data)
   );

   pvec_outreg u_outreg (
      .clock     (clock),
      .reset     (reset),
      .load      (out_load),
      .load_data (out_data),
      .free      (out_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   assign rsp_status      = rsp_data.status;
   assign rsp_agent       = rsp_data.agent;
   assign rsp_other_agent = rsp_data.other_agent;
   assign rsp_time_step   = rsp_data.time_step;

   // one beat in flight: the input side closes right after a beat is taken
   `PVEC_ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && !req_stall, req_stall, "input accepted while a beat is still in flight")
   `PVEC_ASSERT_IMPLY(a_no_check_step0, clock, reset, rsp_valid && rsp_time_step == '0, rsp_status == ST_NONE, "conflict reported at time step 0")
   `PVEC_ASSERT_IMPLY(a_clear_other, clock, reset, rsp_valid && rsp_status == ST_NONE, rsp_other_agent == '0, "other agent named without a conflict")

endmodule

// ===== sim/conflict_report_check.sv =====
`timescale 1ns / 1ps
// Predicts each conflict report from the vertex beats and compares it with the result beats
module conflict_report_check import pvec_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [CFG_W-1:0]    csr_wr_data,
   input  logic                req_valid,
   input  logic                req_stall,
   input  logic [VERTEX_W-1:0] req_vertex,
   input  logic                req_restart,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  logic [STATUS_W-1:0] rsp_status,
   input  logic [AGENT_W-1:0]  rsp_agent,
   input  logic [AGENT_W-1:0]  rsp_other_agent,
   input  logic [STEP_W-1:0]   rsp_time_step,
   output int                  fault_count,
   output int                  open_count
);

   localparam int PRINT_LIMIT = 40;

   logic [VERTEX_W-1:0] row_now  [PVEC_MAX_AGENTS];
   logic [VERTEX_W-1:0] row_last [PVEC_MAX_AGENTS];
   logic [CFG_W-1:0]    agents_reg;
   int unsigned         slot_next;
   logic [STEP_W-1:0]   step_now;
   result_type          expected_reports [$];
   int                  printed;

   function automatic result_type judge_position(input logic [VERTEX_W-1:0] vtx,
                                                 input logic fresh);
      result_type          verdict;
      int unsigned         in_use;
      int unsigned         slot;
      int unsigned         j;
      logic [VERTEX_W-1:0] own_last;
      in_use = (agents_reg == 0) ? 1 :
               ((agents_reg > PVEC_MAX_AGENTS) ? PVEC_MAX_AGENTS : agents_reg);
      if (fresh) begin
         slot_next = 0;
         step_now  = '0;
      end
      slot    = slot_next;
      verdict = '0;
      verdict.status = ST_NONE;
      // step 0 has no earlier step to swap with, so it is never checked
      if (step_now != 0) begin
         own_last = row_last[slot];
         for (j = 0; j < slot && verdict.status == ST_NONE; j++) begin
            if (row_now[j] == vtx) begin
               verdict.status      = ST_VERTEX;
               verdict.other_agent = AGENT_W'(j);
            end else if (row_last[j] == vtx && row_now[j] == own_last) begin
               verdict.status      = ST_EDGE;
               verdict.other_agent = AGENT_W'(j);
            end
         end
      end
      verdict.agent     = AGENT_W'(slot);
      verdict.time_step = step_now;
      row_now[slot] = vtx;
      // a slot at or past a lowered count still closes the step
      if (slot + 1 >= in_use) begin
         row_last  = row_now;
         slot_next = 0;
         if (step_now != STEP_MAX) step_now = step_now + 1'b1;
      end else begin
         slot_next = slot + 1;
      end
      return verdict;
   endfunction

   task automatic flag_field(input string what, input logic [STEP_W-1:0] want,
                             input logic [STEP_W-1:0] got);
      if (got !== want) begin
         fault_count++;
         if (printed < PRINT_LIMIT) begin
            printed++;
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
         end
      end
   endtask

   always @(posedge clock) begin : watch
      result_type seen;
      result_type want;
      result_type next_report;
      if (reset) begin
         expected_reports.delete();
         agents_reg = 7'd1;
         slot_next  = 0;
         step_now   = '0;
         open_count <= 0;
      end else begin
         if (csr_wr_en) agents_reg = csr_wr_data;
         if (rsp_valid && !rsp_stall) begin
            seen = {rsp_status, rsp_agent, rsp_other_agent, rsp_time_step};
            if (expected_reports.size() == 0) begin
               fault_count++;
               if (printed < PRINT_LIMIT) begin
                  printed++;
                  $display("%0t: result beat with none outstanding: expected none, got %0d %0d %0d %0d",
                           $time, seen.status, seen.agent, seen.other_agent, seen.time_step);
               end
            end else begin
               want = expected_reports.pop_front();
               flag_field("status", want.status, seen.status);
               flag_field("agent", want.agent, seen.agent);
               flag_field("other_agent", want.other_agent, seen.other_agent);
               flag_field("time_step", want.time_step, seen.time_step);
            end
         end
         if (req_valid && !req_stall) begin
            next_report      = judge_position(req_vertex, req_restart);
            expected_reports = {expected_reports, next_report};
         end
         open_count <= expected_reports.size();
      end
   end

endmodule

// ===== sim/path_vertex_edge_conflict_check_test.sv =====
`timescale 1ns / 1ps
// Test top for the path conflict checker: stimulus, agent-count writes and the verdict
module path_vertex_edge_conflict_check_test;
   import pvec_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 100;
   localparam int RANDOM_BEATS   = 1700;

   typedef enum int {PACE_FULL, PACE_NONE, PACE_BRISK} pace_type;

   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic                csr_wr_en   = 1'b0;
   logic [CFG_W-1:0]    csr_wr_data = '0;
   logic                req_valid   = 1'b0;
   logic                req_stall;
   logic [VERTEX_W-1:0] req_vertex  = '0;
   logic                req_restart = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall   = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [AGENT_W-1:0]  rsp_agent;
   logic [AGENT_W-1:0]  rsp_other_agent;
   logic [STEP_W-1:0]   rsp_time_step;
   int                  fault_count;
   int                  open_count;

   // stimulus-side view of the path, used only to shape vertices
   pace_type            pace        = PACE_FULL;
   int unsigned         plan_agents = 1;
   int unsigned         plan_slot   = 0;
   logic [VERTEX_W-1:0] plan_now  [PVEC_MAX_AGENTS] = '{default: '0};
   logic [VERTEX_W-1:0] plan_last [PVEC_MAX_AGENTS] = '{default: '0};
   logic [VERTEX_W-1:0] pool_base   = '0;
   int unsigned         pool_span   = 2;

   wire req_fire = req_valid && !req_stall;
   wire rsp_fire = rsp_valid && !rsp_stall;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   path_vertex_edge_conflict_check u_top (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_vertex      (req_vertex),
      .req_restart     (req_restart),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_agent       (rsp_agent),
      .rsp_other_agent (rsp_other_agent),
      .rsp_time_step   (rsp_time_step)
   );

   conflict_report_check u_check (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_vertex      (req_vertex),
      .req_restart     (req_restart),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_agent       (rsp_agent),
      .rsp_other_agent (rsp_other_agent),
      .rsp_time_step   (rsp_time_step),
      .fault_count     (fault_count),
      .open_count      (open_count)
   );

   function automatic int gap_cycles();
      case (pace)
         PACE_NONE:  return 0;
         PACE_BRISK: return ($urandom_range(0, 63) == 0) ? $urandom_range(0, 18) : 0;
         default:    return $urandom_range(0, 18);
      endcase
   endfunction

   function automatic logic [CFG_W-1:0] pick_agents();
      case ($urandom_range(0, 19))
         0:       return '0;
         1, 2:    return CFG_W'(PVEC_MAX_AGENTS);
         3:       return CFG_W'($urandom_range(PVEC_MAX_AGENTS + 1, (1 << CFG_W) - 1));
         4:       return CFG_W'($urandom_range(9, PVEC_MAX_AGENTS - 1));
         default: return CFG_W'($urandom_range(1, 8));
      endcase
   endfunction

   // mostly moves that stay put or step onto a neighbour's last spot, so swaps turn up
   function automatic logic [VERTEX_W-1:0] pick_vertex(input bit fresh);
      int unsigned slot;
      slot = fresh ? 0 : plan_slot;
      case ($urandom_range(0, 9))
         0, 1, 2: return plan_last[slot];
         3, 4, 5: return plan_last[$urandom_range(0, plan_agents - 1)];
         6:       return VERTEX_W'($urandom);
         default: return pool_base + VERTEX_W'($urandom_range(0, pool_span));
      endcase
   endfunction

   task automatic send_position(input logic [VERTEX_W-1:0] vtx, input logic fresh);
      int gap;
      gap = gap_cycles();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_vertex  <= vtx;
      req_restart <= fresh;
      do @(posedge clock); while (!(req_valid && !req_stall));
      if (fresh) plan_slot = 0;
      plan_now[plan_slot] = vtx;
      if (plan_slot + 1 >= plan_agents) begin
         plan_last = plan_now;
         plan_slot = 0;
      end else begin
         plan_slot++;
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (open_count != 0);
   endtask

   task automatic write_agents(input logic [CFG_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      plan_agents = (value == 0) ? 1 : ((value > PVEC_MAX_AGENTS) ? PVEC_MAX_AGENTS : value);
   endtask

   initial begin : result_sink
      int hold;
      wait (!reset);
      forever begin
         hold = gap_cycles();
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || req_fire || rsp_fire) quiet = 0;
         else quiet++;
      end
      $display("TB_ERROR");
      $finish;
   end

   initial begin : stimulus
      int               sent;
      int               beats;
      int unsigned      prior;
      logic [CFG_W-1:0] count_value;
      bit               fresh;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // single agent after reset, then a restart
      send_position(16'h0000, 1'b0);
      send_position(16'hFFFF, 1'b0);
      send_position(16'hFFFF, 1'b1);
      drain();
      // three agents: edge swap, vertex hit, lowest agent wins
      write_agents(7'd3);
      send_position(16'h0005, 1'b1); send_position(16'h0007, 1'b0); send_position(16'h0009, 1'b0);
      send_position(16'h0007, 1'b0); send_position(16'h0005, 1'b0); send_position(16'h0007, 1'b0);
      send_position(16'h0005, 1'b0); send_position(16'h0007, 1'b0); send_position(16'hFFFF, 1'b0);
      send_position(16'h0000, 1'b0); send_position(16'h0000, 1'b0);
      drain();
      write_agents(7'd4);
      send_position(16'h0001, 1'b1); send_position(16'h0002, 1'b0);
      send_position(16'h0003, 1'b0); send_position(16'h0004, 1'b0);
      send_position(16'h0002, 1'b0); send_position(16'h0001, 1'b0);
      drain();
      // count dropped under the running agent index; zero acts as one
      write_agents(7'd0);
      send_position(16'h0003, 1'b0);
      send_position(16'h0008, 1'b0);
      drain();
      write_agents(7'h7F);
      send_position(16'h8000, 1'b1);
      send_position(16'h8000, 1'b0);
      send_position(16'h7FFF, 1'b0);
      drain();

      sent = 0;
      while (sent < RANDOM_BEATS) begin
         case ($urandom_range(0, 4))
            0:       pace = PACE_NONE;
            1:       pace = PACE_BRISK;
            default: pace = PACE_FULL;
         endcase
         prior       = plan_agents;
         count_value = pick_agents();
         write_agents(count_value);
         // rows past the old count hold nothing usable, so a larger count restarts
         fresh = (plan_agents > prior);
         case ($urandom_range(0, 3))
            0:       pool_base = '0;
            1:       pool_base = {VERTEX_W{1'b1}} - VERTEX_W'(2 * plan_agents);
            default: pool_base = VERTEX_W'($urandom);
         endcase
         pool_span = 2 * plan_agents;
         beats = $urandom_range(1, 4 * plan_agents + 8);
         if (beats > RANDOM_BEATS - sent) beats = RANDOM_BEATS - sent;
         repeat (beats) begin
            if ($urandom_range(0, 49) == 0) fresh = 1'b1;
            send_position(pick_vertex(fresh), fresh);
            fresh = 1'b0;
            sent++;
         end
         drain();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fault_count == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule
